>>> hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

  // Store geometry
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Field widths
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;
  localparam int CLAMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  // Configuration port
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int CAP_RESET = 16;

  // Register indexes
  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_e;

  // Request kinds
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // One stored entry
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // Status handed from a cell to the top level
  typedef struct packed {
    logic match;
    logic any_match;
  } cell_stat_t;

endpackage

>>> hw/rtl/lru_key_value_cache_unit.sv
// Channel   Dir  Handshake                Payload
// s_axis    in   tvalid/tready            tdata: key, value; tuser: op
// m_axis    out  tvalid/tready            tdata: read_value, evicted_key;
//                                         tuser: hit, evicted
// apb       in   psel/penable, pready=1   capacity_in_use at byte address 0
//
// A word is registered on acceptance and resolved when the result register can take it:
// all cells compare the key at once and the recency row shifts by one place.
// Sustained rate is one word per cycle while the result register drains;
// a result reaches m_axis_tvalid through the request register and then the result register.
// A stalled result register holds the pending word; the input takes a new
// word in the same cycle the pending one resolves. Reset empties the store.
module lru_key_value_cache_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,  // key[31:0], value[63:32]
  input  logic [0:0]                   s_axis_tuser,  // op[0]
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [63:0]                  m_axis_tdata,  // read_value[31:0], evicted_key[63:32]
  output logic [1:0]                   m_axis_tuser,  // hit[0], evicted[1]
  // Configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lkvc_pkg::APB_AW-1:0]  paddr,
  input  logic [lkvc_pkg::APB_DW-1:0]  pwdata,
  output logic [lkvc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  localparam int N = lkvc_pkg::MAX_ENTRIES;

  logic [lkvc_pkg::CAP_W-1:0]   capacity;
  logic [lkvc_pkg::CLAMP_W-1:0] cap_ext, cap_eff;
  logic [lkvc_pkg::IDX_W-1:0]   full_idx;

  // Request register
  logic                          busy_q, busy_d;
  lkvc_pkg::op_e                 op_q, op_d;
  logic [lkvc_pkg::KEY_W-1:0]    key_q, key_d;
  logic [lkvc_pkg::VALUE_W-1:0]  val_q, val_d;

  // Result register
  logic                          out_valid_q, out_valid_d;
  logic                          hit_q, hit_d, ev_q, ev_d;
  logic [lkvc_pkg::VALUE_W-1:0]  rd_q, rd_d;
  logic [lkvc_pkg::KEY_W-1:0]    evk_q, evk_d;

  logic in_fire, exec;
  logic hit, evict, update;
  logic [lkvc_pkg::VALUE_W-1:0] hit_value;
  logic [lkvc_pkg::KEY_W-1:0]   tail_key;

  lkvc_pkg::entry_t     head;
  lkvc_pkg::entry_t     cell_in  [N];
  lkvc_pkg::entry_t     cell_out [N];
  lkvc_pkg::cell_stat_t stat     [N];
  logic [N-1:0]         any_in;
  logic [N-1:0]         load;
  logic [N-1:0]         valid_vec;

  lkvc_apb u_apb (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  // Capacity clamp: zero acts as one, above the store size acts as full size
  always_comb begin
    cap_ext = lkvc_pkg::CLAMP_W'(capacity);
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = lkvc_pkg::CLAMP_W'(1);
    end else if (cap_ext > lkvc_pkg::CLAMP_W'(N)) begin
      cap_eff = lkvc_pkg::CLAMP_W'(N);
    end
    full_idx = lkvc_pkg::IDX_W'(cap_eff - lkvc_pkg::CLAMP_W'(1));
  end

  // Handshake
  assign exec          = busy_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !busy_q || exec;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    key_d  = key_q;
    val_d  = val_q;
    if (exec) begin
      busy_d = 1'b0;
    end
    if (in_fire) begin
      busy_d = 1'b1;
      op_d   = lkvc_pkg::op_e'(s_axis_tuser[0]);
      key_d  = s_axis_tdata[lkvc_pkg::KEY_W-1:0];
      val_d  = s_axis_tdata[lkvc_pkg::KEY_W +: lkvc_pkg::VALUE_W];
    end
  end

  // Cell row: entry 0 is most recent, valid entries are packed from the head
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_last
      assign any_in[i] = 1'b0;
    end else begin : g_mid
      assign any_in[i] = stat[i+1].any_match;
    end
    if (i == 0) begin : g_head
      assign cell_in[i] = head;
    end else begin : g_body
      assign cell_in[i] = cell_out[i-1];
    end
    assign valid_vec[i] = cell_out[i].valid;

    lkvc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load[i]),
      .entry_i     (cell_in[i]),
      .req_key_i   (key_q),
      .any_match_i (any_in[i]),
      .entry_o     (cell_out[i]),
      .stat_o      (stat[i])
    );
  end

  // Hit value and least-recent key, both one-hot selected
  always_comb begin
    hit_value = '0;
    tail_key  = '0;
    for (int i = 0; i < N; i++) begin
      if (stat[i].match) begin
        hit_value = hit_value | cell_out[i].value;
      end
      if (valid_vec[i] && ((i == N - 1) || !valid_vec[(i + 1) % N])) begin
        tail_key = tail_key | cell_out[i].key;
      end
    end
  end

  assign hit    = stat[0].any_match;
  assign evict  = (op_q == lkvc_pkg::OP_PUT) && !hit && valid_vec[full_idx];
  assign update = exec && (hit || (op_q == lkvc_pkg::OP_PUT));

  // New head entry: the touched or inserted key
  always_comb begin
    head.valid = 1'b1;
    head.key   = key_q;
    head.value = (op_q == lkvc_pkg::OP_PUT) ? val_q : hit_value;
  end

  // Shift enables: up to the hit on a hit, else over the filled run
  always_comb begin
    load = '0;
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        load[i] = update;
      end else if (hit) begin
        load[i] = update && stat[i].any_match;
      end else if (evict) begin
        load[i] = update && valid_vec[i];
      end else begin
        load[i] = update && valid_vec[(i + N - 1) % N];
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    hit_d       = hit_q;
    ev_d        = ev_q;
    rd_d        = rd_q;
    evk_d       = evk_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (exec) begin
      out_valid_d = 1'b1;
      hit_d       = hit;
      ev_d        = evict;
      rd_d        = (hit && (op_q == lkvc_pkg::OP_GET)) ? hit_value : '0;
      evk_d       = evict ? tail_key : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    key_q <= key_d;
    val_q <= val_d;
    hit_q <= hit_d;
    ev_q  <= ev_d;
    rd_q  <= rd_d;
    evk_q <= evk_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {evk_q, rd_q};
  assign m_axis_tuser  = {ev_q, hit_q};

endmodule

>>> hw/rtl/lkvc_cell.sv
module lkvc_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  lkvc_pkg::entry_t        entry_i,
  input  logic [lkvc_pkg::KEY_W-1:0] req_key_i,
  input  logic                    any_match_i,
  output lkvc_pkg::entry_t        entry_o,
  output lkvc_pkg::cell_stat_t    stat_o
);

  logic                          valid_q, valid_d;
  logic [lkvc_pkg::KEY_W-1:0]    key_q, key_d;
  logic [lkvc_pkg::VALUE_W-1:0]  value_q, value_d;
  logic                          match;

  // Key compare against the pending request
  assign match = valid_q && (key_q == req_key_i);

  // Match ripples toward the head so each cell knows a hit lies at or behind it
  assign stat_o.match     = match;
  assign stat_o.any_match = match | any_match_i;

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;

  // Take the neighbor's entry when told to
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (load_i) begin
      valid_d = entry_i.valid;
      key_d   = entry_i.key;
      value_d = entry_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule

>>> hw/rtl/lkvc_apb.sv
module lkvc_apb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lkvc_pkg::APB_AW-1:0]  paddr,
  input  logic [lkvc_pkg::APB_DW-1:0]  pwdata,
  output logic [lkvc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output logic [lkvc_pkg::CAP_W-1:0]   capacity_o
);

  logic [lkvc_pkg::CAP_W-1:0] cap_q, cap_d;
  lkvc_pkg::reg_idx_e         reg_idx;
  logic                       wr_en;

  // Word-aligned decode, low address bits ignored
  assign reg_idx = lkvc_pkg::reg_idx_e'(paddr[lkvc_pkg::APB_AW-1]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cap_d = cap_q;
    if (wr_en && (reg_idx == lkvc_pkg::REG_CAPACITY)) begin
      cap_d = pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      lkvc_pkg::REG_CAPACITY: prdata = lkvc_pkg::APB_DW'(cap_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_W'(lkvc_pkg::CAP_RESET);
    end else begin
      cap_q <= cap_d;
    end
  end

  assign capacity_o = cap_q;

endmodule

>>> verif/lru_key_value_cache_unit_chk.sv
module lru_key_value_cache_unit_chk
  import lkvc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request stream
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,   // key[31:0], value[63:32]
  input  logic [0:0]          s_axis_tuser,   // op[0]
  // Result stream
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [63:0]         m_axis_tdata,   // read_value[31:0], evicted_key[63:32]
  input  logic [1:0]          m_axis_tuser,   // hit[0], evicted[1]
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  input  logic [APB_DW-1:0]   prdata,
  input  logic                pready,
  // Tallies for the top
  output int                  err_count,
  output int                  pending_count,
  output int                  hit_count,
  output int                  evict_count
);

  localparam logic [APB_AW-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
  } lookup_result_t;

  // Shadow copy of the store
  logic [CAP_W-1:0]   capacity_q;
  logic               valid_q [MAX_ENTRIES];
  logic [KEY_W-1:0]   key_q   [MAX_ENTRIES];
  logic [VALUE_W-1:0] value_q [MAX_ENTRIES];
  logic [IDX_W-1:0]   rank_q  [MAX_ENTRIES];
  logic [CNT_W-1:0]   fill_q;

  lookup_result_t expected_results [$];
  lookup_result_t got, want;

  // Entry s becomes most recent; the ones that were newer age by one
  function automatic void promote(int s);
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (valid_q[i] && rank_q[i] < rank_q[s]) rank_q[i] = rank_q[i] + 1'b1;
    rank_q[s] = '0;
  endfunction

  function automatic lookup_result_t lookup_and_update(op_e op, logic [KEY_W-1:0] k,
                                                       logic [VALUE_W-1:0] v);
    lookup_result_t res;
    int found, lru, slot, eff;
    res   = '0;
    found = -1;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (valid_q[i] && key_q[i] == k && found < 0) found = i;
    res.hit = (found >= 0);

    if (op == OP_GET) begin
      if (res.hit) begin
        res.read_value = value_q[found];
        promote(found);
      end
    end else if (res.hit) begin
      value_q[found] = v;
      promote(found);
    end else begin
      // zero capacity acts as one, oversize as the full store
      eff = (capacity_q == 0) ? 1 : (capacity_q > MAX_ENTRIES) ? MAX_ENTRIES : capacity_q;
      if (fill_q >= eff && fill_q > 0) begin
        lru = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (valid_q[i] && (lru < 0 || rank_q[i] > rank_q[lru])) lru = i;
        if (lru >= 0) begin
          res.evicted     = 1'b1;
          res.evicted_key = key_q[lru];
          valid_q[lru]    = 1'b0;
          fill_q          = fill_q - 1'b1;
        end
      end
      slot = -1;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_q[i]) rank_q[i] = rank_q[i] + 1'b1;
        else if (slot < 0) slot = i;
      end
      if (slot >= 0) begin
        valid_q[slot] = 1'b1;
        key_q[slot]   = k;
        value_q[slot] = v;
        rank_q[slot]  = '0;
        fill_q        = fill_q + 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q = CAP_W'(CAP_RESET);
      fill_q     = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        valid_q[i] = 1'b0;
        key_q[i]   = '0;
        value_q[i] = '0;
        rank_q[i]  = '0;
      end
      expected_results.delete();
      err_count     = 0;
      pending_count = 0;
      hit_count     = 0;
      evict_count   = 0;
    end else begin
      // register access
      if (psel && penable && pready && paddr == CAP_ADDR) begin
        if (pwrite) begin
          capacity_q = pwdata[CAP_W-1:0];
        end else if (prdata !== APB_DW'(capacity_q)) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: capacity read back %h, expected %h", $time, prdata, capacity_q);
        end
      end

      // retire one result word against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tuser[1], m_axis_tdata[63:32]};
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result word with nothing pending: %h", $time, got);
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit || got.read_value !== want.read_value ||
              got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: mismatch exp/act hit %b/%b value %h/%h evicted %b/%b key %h/%h",
                       $time, want.hit, got.hit, want.read_value, got.read_value,
                       want.evicted, got.evicted, want.evicted_key, got.evicted_key);
          end
        end
      end

      // predict each accepted request word
      if (s_axis_tvalid && s_axis_tready) begin
        want = lookup_and_update(op_e'(s_axis_tuser[0]), s_axis_tdata[31:0],
                                 s_axis_tdata[63:32]);
        if (want.hit) hit_count++;
        if (want.evicted) evict_count++;
        expected_results.push_back(want);
      end
      pending_count = expected_results.size();
    end
  end

endmodule

>>> verif/lru_key_value_cache_unit_tb.sv
module lru_key_value_cache_unit_tb;
  import lkvc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 80;
  localparam int N_PHASES       = 10;
  localparam int PHASE_WORDS    = 110;
  localparam logic [APB_AW-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
  localparam logic [APB_AW-1:0] SPARE_ADDR = {REG_NONE, 2'b00};

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [63:0]        s_axis_tdata;   // key[31:0], value[63:32]
  logic [0:0]         s_axis_tuser;   // op[0]
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [63:0]        m_axis_tdata;   // read_value[31:0], evicted_key[63:32]
  logic [1:0]         m_axis_tuser;   // hit[0], evicted[1]
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  int err_count, pending_count, hit_count, evict_count;
  int sent_words, n_settings, idle_cycles, hold_left;
  bit calm, hold_req;

  // per phase: capacity written and size of the key pool
  int unsigned phase_cap  [N_PHASES] = '{16, 1, 0, 5, 31, 17, 8, 2, 16, 3};
  int unsigned phase_pool [N_PHASES] = '{22, 3, 2, 9, 24, 20, 12, 4, 30, 6};

  lru_key_value_cache_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  lru_key_value_cache_unit_chk u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .err_count     (err_count),
    .pending_count (pending_count),
    .hit_count     (hit_count),
    .evict_count   (evict_count)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 27);
  endfunction

  // Entered and left at a falling edge
  task automatic send_word(op_e op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, k};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_words++;
    @(negedge clk_i);
  endtask

  task automatic apb_access(bit wr, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Let every outstanding result drain, then write and read back the capacity
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    s_axis_tvalid <= 1'b0;
    wait (pending_count == 0);
    @(negedge clk_i);
    apb_access(1'b1, CAP_ADDR, APB_DW'(cap));
    apb_access(1'b0, CAP_ADDR, '0);
    n_settings++;
  endtask

  // Mostly keys from a small pool so hits and evictions are frequent
  task automatic random_phase(int unsigned n_words, int unsigned pool_size);
    logic [KEY_W-1:0] pool [32];
    logic [KEY_W-1:0] k;
    op_e op;
    for (int i = 0; i < 32; i++) pool[i] = $urandom();
    repeat (n_words) begin
      op = op_e'($urandom_range(1));
      if ($urandom_range(9) == 0) k = $urandom();
      else k = pool[$urandom_range(pool_size - 1)];
      send_word(op, k, $urandom());
    end
  endtask

  // Result side: random stalls plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !idle_now();
      end
    end
  end

  // Watchdog: cycles without any handshake on the request, result or register port
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    sent_words    = 0;
    n_settings    = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset capacity, empty store, extreme keys and values
    send_word(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_word(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_word(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_word(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(OP_GET, 32'h1234_5678, 32'h0000_0000);
    // update of a present key
    send_word(OP_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
    send_word(OP_GET, 32'h0000_0000, 32'h0000_0000);

    // capacity below the fill: each miss evicts one, fill stays
    set_capacity(5'd2);
    send_word(OP_PUT, 32'h0000_0001, 32'h0000_0001);
    send_word(OP_PUT, 32'h0000_0002, 32'h0000_0002);
    send_word(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(OP_PUT, 32'h0000_0003, 32'h0000_0003);

    // zero acts as one
    set_capacity(5'd0);
    send_word(OP_PUT, 32'h0000_0004, 32'h0000_0004);
    send_word(OP_GET, 32'h0000_0004, 32'h0000_0000);
    send_word(OP_PUT, 32'h0000_0004, 32'hDEAD_BEEF);

    // oversize values clamp to the full store
    set_capacity(5'd31);
    send_word(OP_PUT, 32'h0000_0005, 32'h0000_0005);
    send_word(OP_PUT, 32'h0000_0006, 32'h0000_0006);
    set_capacity(5'd17);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    apb_access(1'b1, SPARE_ADDR, 32'h0000_0001);  // unmapped, ignored
    send_word(OP_PUT, 32'h0000_0007, 32'h0000_0007);
    set_capacity(5'd1);
    send_word(OP_PUT, 32'h0000_0008, 32'h0000_0008);

    // random phases across capacities
    for (int p = 0; p < N_PHASES; p++) begin
      set_capacity(CAP_W'(phase_cap[p]));
      calm = (p == 2);
      if (p == 6) hold_req = 1'b1;
      random_phase(PHASE_WORDS, phase_pool[p]);
      calm = 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    wait (pending_count == 0);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d requests over %0d capacity settings: %0d hits, %0d evictions",
             sent_words, n_settings, hit_count, evict_count);
    $display("Mismatches: %0d, results still outstanding: %0d", err_count, pending_count);
    if (err_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_cell.sv
hw/rtl/lkvc_apb.sv
hw/rtl/lru_key_value_cache_unit.sv
verif/lru_key_value_cache_unit_chk.sv
verif/lru_key_value_cache_unit_tb.sv
